FILE: sv/deq_pkg.sv
// shared constants, codes and item types of the double-ended queue
package deq_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4,
      OP_WRITE      = 3'd5,
      OP_INSERT     = 3'd6,
      OP_ERASE      = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      op_type      req_type;
      logic [8:0]  position;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [31:0] value_out;
      status_type  status;
      logic [8:0]  fill_count;
   } rsp_type;

   // physical slot of the element idx places behind the front
   function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                 input logic [COUNT_W-1:0] idx);
      logic [COUNT_W:0] sum;
      sum = (COUNT_W + 1)'(head) + (COUNT_W + 1)'(idx);
      if (sum >= (COUNT_W + 1)'(CAPACITY)) begin
         sum = sum - (COUNT_W + 1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

FILE: sv/deq_ram.sv
// generic simple dual-port ram with registered read
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/deq_seq.sv
// sequencer: pointer state, request decode and read-modify-write of the element ram
module deq_seq (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  deq_pkg::req_type req_data,
   output logic            res_valid,
   input  logic            res_ready,
   output deq_pkg::rsp_type res_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_SHIFT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   deq_pkg::op_type                   op_ff, op_in;
   logic [8:0]                        pos_ff, pos_in;
   logic [deq_pkg::DATA_WIDTH-1:0]    val_ff, val_in;
   logic [deq_pkg::ADDR_W-1:0]        head_ff, head_in;
   logic [deq_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [deq_pkg::COUNT_W-1:0]       k_ff, k_in;
   logic                              pend_ff, pend_in;
   logic [deq_pkg::ADDR_W-1:0]        pdst_ff, pdst_in;
   logic [deq_pkg::DATA_WIDTH-1:0]    rval_ff, rval_in;
   deq_pkg::status_type               stat_ff, stat_in;

   logic                              ram_we;
   logic [deq_pkg::ADDR_W-1:0]        ram_waddr;
   logic [deq_pkg::DATA_WIDTH-1:0]    ram_wdata;
   logic                              ram_re;
   logic [deq_pkg::ADDR_W-1:0]        ram_raddr;
   logic [deq_pkg::DATA_WIDTH-1:0]    ram_rdata;

   logic                              is_full;
   logic                              is_empty;
   logic                              is_ins;
   logic                              issue;
   logic [deq_pkg::COUNT_W-1:0]       k_src;
   logic [deq_pkg::COUNT_W-1:0]       k_dst;
   logic [deq_pkg::ADDR_W-1:0]        head_dec;
   logic [deq_pkg::ADDR_W-1:0]        head_inc;

   deq_ram #(
      .WIDTH(deq_pkg::DATA_WIDTH),
      .DEPTH(deq_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign is_full  = count_ff == deq_pkg::COUNT_W'(deq_pkg::CAPACITY);
   assign is_empty = count_ff == '0;
   assign is_ins   = op_ff == deq_pkg::OP_INSERT;
   assign head_dec = (head_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::CAPACITY - 1)
                                     : head_ff - 1'b1;
   assign head_inc = (head_ff == deq_pkg::ADDR_W'(deq_pkg::CAPACITY - 1)) ? '0
                                     : head_ff + 1'b1;

   // insert moves elements toward the back starting at the tail, erase toward the front
   assign issue = is_ins ? (k_ff > pos_ff) : (k_ff < count_ff);
   assign k_src = is_ins ? k_ff - 1'b1 : k_ff;
   assign k_dst = is_ins ? k_ff : k_ff - 1'b1;

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      k_in      = k_ff;
      pend_in   = 1'b0;
      pdst_in   = pdst_ff;
      rval_in   = rval_ff;
      stat_in   = stat_ff;
      ram_we    = 1'b0;
      ram_waddr = deq_pkg::slot_of(head_ff, count_ff);
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = deq_pkg::slot_of(head_ff, pos_ff);
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.req_type;
               pos_in   = req_data.position;
               val_in   = req_data.value_in;
               rval_in  = '0;
               stat_in  = deq_pkg::STAT_OK;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (op_ff)
               deq_pkg::OP_PUSH_BACK: begin
                  if (is_full) begin
                     stat_in = deq_pkg::STAT_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               deq_pkg::OP_PUSH_FRONT: begin
                  if (is_full) begin
                     stat_in = deq_pkg::STAT_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = head_dec;
                     head_in   = head_dec;
                     count_in  = count_ff + 1'b1;
                  end
               end
               deq_pkg::OP_POP_BACK: begin
                  if (is_empty) begin
                     stat_in = deq_pkg::STAT_EMPTY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = deq_pkg::slot_of(head_ff, count_ff - 1'b1);
                     state_in  = ST_FETCH;
                  end
               end
               deq_pkg::OP_POP_FRONT: begin
                  if (is_empty) begin
                     stat_in = deq_pkg::STAT_EMPTY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = head_ff;
                     state_in  = ST_FETCH;
                  end
               end
               deq_pkg::OP_READ, deq_pkg::OP_ERASE: begin
                  if (pos_ff >= count_ff) begin
                     stat_in = deq_pkg::STAT_RANGE;
                  end else begin
                     ram_re   = 1'b1;
                     k_in     = pos_ff + 1'b1;
                     state_in = ST_FETCH;
                  end
               end
               deq_pkg::OP_WRITE: begin
                  if (pos_ff >= count_ff) begin
                     stat_in = deq_pkg::STAT_RANGE;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = deq_pkg::slot_of(head_ff, pos_ff);
                  end
               end
               deq_pkg::OP_INSERT: begin
                  // range is checked ahead of fullness
                  if (pos_ff > count_ff) begin
                     stat_in = deq_pkg::STAT_RANGE;
                  end else if (is_full) begin
                     stat_in = deq_pkg::STAT_FULL;
                  end else begin
                     k_in     = count_ff;
                     state_in = ST_SHIFT;
                  end
               end
               default: begin
                  stat_in = deq_pkg::STAT_OK;
               end
            endcase
         end
         ST_FETCH: begin
            rval_in  = ram_rdata;
            state_in = ST_DONE;
            case (op_ff)
               deq_pkg::OP_POP_BACK: begin
                  count_in = count_ff - 1'b1;
               end
               deq_pkg::OP_POP_FRONT: begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
               deq_pkg::OP_ERASE: begin
                  state_in = ST_SHIFT;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_SHIFT: begin
            // one element read per cycle, written back to its neighbor slot in the next cycle
            if (issue) begin
               ram_re    = 1'b1;
               ram_raddr = deq_pkg::slot_of(head_ff, k_src);
               pdst_in   = deq_pkg::slot_of(head_ff, k_dst);
               pend_in   = 1'b1;
               k_in      = is_ins ? k_ff - 1'b1 : k_ff + 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pdst_ff;
               ram_wdata = ram_rdata;
            end else if (!issue) begin
               state_in = ST_DONE;
               if (is_ins) begin
                  ram_we    = 1'b1;
                  ram_waddr = deq_pkg::slot_of(head_ff, pos_ff);
                  count_in  = count_ff + 1'b1;
               end else begin
                  count_in  = count_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      k_ff    <= k_in;
      pdst_ff <= pdst_in;
      rval_ff <= rval_in;
      stat_ff <= stat_in;
   end

   assign res_data.value_out  = rval_ff;
   assign res_data.status     = stat_ff;
   assign res_data.fill_count = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::COUNT_W'(deq_pkg::CAPACITY))
      else $error("element count beyond capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write of the same slot in one cycle");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) ||
      (count_ff == $past(count_ff) - 1'b1))
      else $error("element count moved by more than one");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted item not taken into execution");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && stat_ff != deq_pkg::STAT_OK) |->
      (count_ff == $past(count_ff, 2)))
      else $error("failed request changed the element count");

endmodule

FILE: sv/double_ended_queue_top.sv
// top level of the double-ended queue: request intake, sequencer and result register
//
// A 256-entry double-ended queue of 32-bit elements kept in one synchronous RAM as a
// circular buffer. Items are taken one at a time; each gives exactly one result with the
// element read or removed, a status and the new fill count. Pops, reads and erase go
// through one registered RAM read. Insert and erase shift the elements from the position
// onward through the single RAM read and write port, one element a cycle. The result
// sits in an output register, so the sequencer finishes its item while the previous
// result still waits to be taken.
module double_ended_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);

   logic             res_valid;
   logic             res_ready;
   deq_pkg::rsp_type res_data;
   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_ff;

   deq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   // output register frees up in the same cycle its item is taken
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
